FILE: sv/spsm_pkg.sv
// Shared types, codes and small modular helpers for the segmented sieve marker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package spsm_pkg;

  localparam int unsigned SieveWordsDefault = 16384;
  localparam int unsigned WordIdxW          = 14;
  localparam int unsigned PrimeW            = 32;
  localparam int unsigned IdxW              = 34;  // bit offsets incl. 2p steps
  localparam int unsigned QueueDepth        = 2;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_MARK  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] MOD_THREE = 3'd3;
  localparam logic [2:0] MOD_FIVE  = 3'd5;
  localparam logic [2:0] MOD_SEVEN = 3'd7;

  localparam logic [63:0] EvenBits = 64'h5555_5555_5555_5555;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_MARK,
    KIND_READ,
    KIND_NOP
  } spsm_kind_e;

  typedef struct packed {
    spsm_kind_e        kind;
    logic [1:0]        action;
    logic [IdxW-1:0]   idx;
    logic [IdxW-1:0]   step;
    logic [63:0]       mask;
  } spsm_cmd_t;

  // v below 16*m: restoring reduction in four conditional subtracts
  function automatic logic [2:0] red_small(input logic [6:0] v, input logic [2:0] m);
    logic [6:0] x;
    x = v;
    for (int j = 3; j >= 0; j--) begin
      if (x >= (7'(m) << j)) begin
        x = x - (7'(m) << j);
      end
    end
    return x[2:0];
  endfunction

  // (a - b) mod m for a, b already below m
  function automatic logic [2:0] sub_mod(input logic [2:0] a, input logic [2:0] b,
                                         input logic [2:0] m);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, m} - {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[2:0];
  endfunction

  // 4 = 1 mod 3: sum base-4 digits
  function automatic logic [2:0] mod_three(input logic [WordIdxW-1:0] w);
    logic [6:0] s;
    s = '0;
    for (int j = 0; j < 7; j++) begin
      s = s + 7'(w[2*j +: 2]);
    end
    return red_small(s, MOD_THREE);
  endfunction

  // 16 = 1 mod 5: sum nibbles
  function automatic logic [2:0] mod_five(input logic [WordIdxW-1:0] w);
    logic [6:0] s;
    s = 7'(w[3:0]) + 7'(w[7:4]) + 7'(w[11:8]) + 7'(w[13:12]);
    return red_small(s, MOD_FIVE);
  endfunction

  // 8 = 1 mod 7: sum octal digits
  function automatic logic [2:0] mod_seven(input logic [WordIdxW-1:0] w);
    logic [6:0] s;
    s = 7'(w[2:0]) + 7'(w[5:3]) + 7'(w[8:6]) + 7'(w[11:9]) + 7'(w[13:12]);
    return red_small(s, MOD_SEVEN);
  endfunction

endpackage

`default_nettype wire

FILE: sv/spsm_front.sv
// Front end: item register, configuration residues and item classification.
// Depends on spsm_pkg; feeds spsm_queue.
`timescale 1ns / 1ps
`default_nettype none

module spsm_front import spsm_pkg::*; #(
  parameter int unsigned SIEVE_WORDS = SieveWordsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire logic [1:0]          action_i,
  input  wire logic [PrimeW-1:0]   sieving_prime_i,
  input  wire logic [PrimeW-1:0]   start_residue_i,
  input  wire logic [WordIdxW-1:0] word_index_i,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [2:0]          cfg_data_i,
  input  wire logic                q_full_i,
  output logic                     hold_o,
  output logic                     push_o,
  output spsm_cmd_t                cmd_o
);

  localparam logic [1:0] REG_THREE = 2'd0;
  localparam logic [1:0] REG_FIVE  = 2'd1;
  localparam logic [1:0] REG_SEVEN = 2'd2;

  logic                v_q, v_d;
  logic [1:0]          act_q;
  logic [PrimeW-1:0]   p_q, r_q;
  logic [WordIdxW-1:0] w_q;
  logic [1:0]          m3_q;
  logic [2:0]          m5_q, m7_q;

  logic [PrimeW:0]     diff_p, diff_2p, first;
  logic                w_in_range;
  logic [2:0]          o3, o5, o7, t3, t5, t7;
  logic [63:0]         mask;

  assign push_o = v_q & ~q_full_i;
  assign hold_o = v_q & q_full_i;
  assign v_d    = load_i | (v_q & ~push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= 1'b0;
      m3_q <= '0;
      m5_q <= '0;
      m7_q <= '0;
    end else begin
      v_q <= v_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_THREE: m3_q <= cfg_data_i[1:0];
          REG_FIVE:  m5_q <= cfg_data_i;
          REG_SEVEN: m7_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      act_q <= action_i;
      p_q   <= sieving_prime_i;
      r_q   <= start_residue_i;
      w_q   <= word_index_i;
    end
  end

  // First odd multiple: p - r when odd, else 2p - r; r of zero lands on p.
  assign diff_p  = {1'b0, p_q} - {1'b0, r_q};
  assign diff_2p = {p_q, 1'b0} - {1'b0, r_q};
  always_comb begin
    if (r_q == '0) begin
      first = {1'b0, p_q};
    end else if (diff_p[0]) begin
      first = diff_p;
    end else begin
      first = diff_2p;
    end
  end

  assign w_in_range = 32'(w_q) < 32'(SIEVE_WORDS);

  // Wheel: offset i = 64w + k hits residue o when k mod m equals (o - 64w) mod m.
  assign o3 = sub_mod(3'd0, red_small(7'(m3_q), MOD_THREE), MOD_THREE);
  assign o5 = sub_mod(3'd0, red_small(7'(m5_q), MOD_FIVE), MOD_FIVE);
  assign o7 = sub_mod(3'd0, red_small(7'(m7_q), MOD_SEVEN), MOD_SEVEN);
  assign t3 = sub_mod(o3, mod_three(w_q), MOD_THREE);
  // 64 = -1 mod 5
  assign t5 = sub_mod(o5, sub_mod(3'd0, mod_five(w_q), MOD_FIVE), MOD_FIVE);
  assign t7 = sub_mod(o7, mod_seven(w_q), MOD_SEVEN);

  for (genvar k = 0; k < 64; k++) begin : g_mask
    assign mask[k] = ((k % 2) == 1) && (3'(k % 3) != t3) && (3'(k % 5) != t5) &&
                     (3'(k % 7) != t7);
  end

  always_comb begin
    cmd_o.action = act_q;
    cmd_o.idx    = IdxW'(first);
    cmd_o.step   = IdxW'({p_q, 1'b0});
    cmd_o.mask   = mask;
    unique case (act_q)
      ACT_CLEAR: cmd_o.kind = KIND_CLEAR;
      ACT_MARK: begin
        cmd_o.kind = ((p_q < 32'd3) || (r_q >= p_q)) ? KIND_NOP : KIND_MARK;
      end
      ACT_READ: begin
        cmd_o.kind = w_in_range ? KIND_READ : KIND_NOP;
        cmd_o.idx  = IdxW'({w_q, 6'b0});
      end
      default: cmd_o.kind = KIND_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/spsm_queue.sv
// Short command queue between front end and back end.
// Depends on spsm_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module spsm_queue import spsm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire spsm_cmd_t cmd_i,
  input  wire logic      pop_i,
  output logic           full_o,
  output logic           empty_o,
  output spsm_cmd_t      cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  spsm_cmd_t        slot_q [QueueDepth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    cnt_q;

  assign full_o  = cnt_q == (PtrW+1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign cmd_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/spsm_back.sv
// Back end: bitmap memory, clearing sweep, mark walk and survivor read.
// Depends on spsm_pkg; takes commands from spsm_queue.
`timescale 1ns / 1ps
`default_nettype none

module spsm_back import spsm_pkg::*; #(
  parameter int unsigned SIEVE_WORDS = SieveWordsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_empty_i,
  input  wire spsm_cmd_t cmd_i,
  output logic           pop_o,
  output logic           init_o,
  output logic           valid_o,
  output logic [1:0]     done_action_o,
  output logic [63:0]    survivor_word_o
);

  localparam int unsigned AW = (SIEVE_WORDS > 1) ? $clog2(SIEVE_WORDS) : 1;
  localparam logic [AW-1:0]   LastWord  = AW'(SIEVE_WORDS - 1);
  localparam logic [IdxW-1:0] TotalBits = IdxW'(SIEVE_WORDS) << 6;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_MREAD  = 3'd2;
  localparam logic [2:0] ST_MWRITE = 3'd3;
  localparam logic [2:0] ST_RWAIT  = 3'd4;

  logic [63:0]     mem [SIEVE_WORDS];
  logic [63:0]     rdata_q;

  logic [2:0]      state_q, state_d;
  logic            init_q, init_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d, step_q, step_d;
  logic [63:0]     mask_q, mask_d;
  logic [1:0]      act_q, act_d;
  logic            valid_q, res_v;
  logic [1:0]      res_act_q, res_act;
  logic [63:0]     res_word_q, res_word;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [63:0]     wdata;

  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    step_d   = step_q;
    mask_d   = mask_q;
    act_d    = act_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = idx_q[AW+5:6];
    wdata    = rdata_q | (64'd1 << idx_q[5:0]);
    raddr    = idx_q[AW+5:6];
    res_v    = 1'b0;
    res_act  = act_q;
    res_word = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o  = 1'b1;
          act_d  = cmd_i.action;
          idx_d  = cmd_i.idx;
          step_d = cmd_i.step;
          mask_d = cmd_i.mask;
          unique case (cmd_i.kind)
            KIND_CLEAR: begin
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            KIND_MARK: state_d = ST_MREAD;
            KIND_READ: begin
              raddr   = cmd_i.idx[AW+5:6];
              state_d = ST_RWAIT;
            end
            default: begin
              res_v   = 1'b1;
              res_act = cmd_i.action;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        if (cnt_q == LastWord) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
          res_v   = ~init_q;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MREAD: begin
        if (idx_q < TotalBits) begin
          state_d = ST_MWRITE;
        end else begin
          res_v   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_MWRITE: begin
        we      = 1'b1;
        idx_d   = idx_q + step_q;
        state_d = ST_MREAD;
      end
      ST_RWAIT: begin
        res_v    = 1'b1;
        res_word = ~rdata_q & mask_q;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      init_q  <= 1'b1;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      cnt_q   <= cnt_d;
      valid_q <= res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    step_q <= step_d;
    mask_q <= mask_d;
    act_q  <= act_d;
    if (res_v) begin
      res_act_q  <= res_act;
      res_word_q <= res_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign init_o          = init_q;
  assign valid_o         = valid_q;
  assign done_action_o   = res_act_q;
  assign survivor_word_o = res_word_q;

endmodule

`default_nettype wire

FILE: sv/segmented_prime_sieve_marker_core.sv
// Top level of the segmented sieve marker: front end, command queue, back end.
// Depends on spsm_pkg, spsm_front, spsm_queue and spsm_back.
`timescale 1ns / 1ps
`default_nettype none

// A bitmap of SIEVE_WORDS 64-bit words holds one composite flag per offset
// from an even start number. An item is taken at a clock edge with start_i
// high and busy_o low; every item gives exactly one result, shown on the
// result ports for a single cycle while valid_o is high, and results come
// out in item order. There is no back-pressure on results: the receiver
// must take each one as it appears. The front end registers an item,
// classifies it combinationally and hands it through a two-deep queue, so a
// new item is normally taken while the previous one is still being carried out.
// Back-end steps per item, over the bitmap memory:
//   clear  - the queue pop, then one word written per cycle over all
//            SIEVE_WORDS words;
//   mark   - the queue pop, then a read and a write back per bit set, and a
//            final bound check;
//   read   - the queue pop with memory read, then the masked word;
//   others - the queue pop alone (small prime, residue not below the prime, word
//            out of range, unknown action all return a zero word).
// An item passes through the front register and the queue before the back end
// can take it, and its result shows in the cycle after its last back-end step.
// After reset the bitmap is swept to zero while busy_o
// stays high; configuration writes are taken at any time through a port
// that is always ready. Write the wheel residues only while the block is
// idle.
module segmented_prime_sieve_marker_core import spsm_pkg::*; #(
  parameter int unsigned SIEVE_WORDS = SieveWordsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // item channel
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [PrimeW-1:0]   sieving_prime_i,
  input  wire logic [PrimeW-1:0]   start_residue_i,
  input  wire logic [WordIdxW-1:0] word_index_i,
  // result channel
  output logic                     valid_o,
  output logic [1:0]               done_action_o,
  output logic [63:0]              survivor_word_o,
  // configuration channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [2:0]          cfg_data_i
);

  logic      load;
  logic      hold;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;
  logic      init_busy;
  spsm_cmd_t front_cmd;
  spsm_cmd_t queue_cmd;

  // Stall when the front register cannot drain, or while the reset sweep runs.
  assign busy_o      = hold | init_busy;
  assign load        = start_i & ~busy_o;
  assign cfg_ready_o = 1'b1;

  spsm_front #(
    .SIEVE_WORDS (SIEVE_WORDS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .action_i        (action_i),
    .sieving_prime_i (sieving_prime_i),
    .start_residue_i (start_residue_i),
    .word_index_i    (word_index_i),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_full_i        (q_full),
    .hold_o          (hold),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  spsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .cmd_o   (queue_cmd)
  );

  spsm_back #(
    .SIEVE_WORDS (SIEVE_WORDS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .cmd_i           (queue_cmd),
    .pop_o           (pop),
    .init_o          (init_busy),
    .valid_o         (valid_o),
    .done_action_o   (done_action_o),
    .survivor_word_o (survivor_word_o)
  );

endmodule

`default_nettype wire

FILE: sv/spsm_checker.sv
// Port-level checks for the sieve marker, bound to the top level.
// Depends on spsm_pkg and segmented_prime_sieve_marker_core.
`timescale 1ns / 1ps
`default_nettype none

module spsm_checker import spsm_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        busy_o,
  input wire logic        valid_o,
  input wire logic [1:0]  done_action_o,
  input wire logic [63:0] survivor_word_o
);

  // bitmap sweep after reset keeps the item port closed
  a_busy_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> busy_o)
    else $error("item port open during reset sweep");

  a_zero_unless_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (done_action_o != ACT_READ)) |-> (survivor_word_o == '0))
    else $error("non-read result carries survivors");

  // even offsets can never survive
  a_odd_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (done_action_o == ACT_READ)) |-> ((survivor_word_o & EvenBits) == '0))
    else $error("survivor at even offset");

endmodule

bind segmented_prime_sieve_marker_core spsm_checker u_spsm_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking bench for segmented_prime_sieve_marker_core: directed and random items,
// in-bench composite bitmap and wheel filter predict every result.
// Depends on spsm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

// Structure
//   stimulus      initial block: reset, residue writes while idle, fills pending_items
//                 phase by phase and drains between phases
//   item_driver   clocked: offers pending items on start_i, predicts each one taken
//   result_monitor clocked: checks every valid_o cycle against the oldest prediction
// Each item yields exactly one result and results keep item order, so a plain FIFO
// of predictions is enough. Results cannot be held off, hence no receiver stalls.
module tb_top import spsm_pkg::*; ();

  localparam int unsigned     SieveWords   = SieveWordsDefault;
  localparam logic [63:0]     TotalBits    = 64'(SieveWords) * 64;
  localparam logic [1:0]      ActUnknown   = 2'd3;
  localparam logic [1:0]      RegModThree  = 2'd0;
  localparam logic [1:0]      RegModFive   = 2'd1;
  localparam logic [1:0]      RegModSeven  = 2'd2;
  localparam logic [1:0]      RegSpare     = 2'd3;
  localparam int unsigned     Phases       = 8;
  localparam int unsigned     PhaseItems   = 153;
  localparam int unsigned     SettleCycles = 8;
  localparam longint unsigned LimitNs      = 64'd120_000_000;

  typedef struct {
    logic [1:0]          action;
    logic [PrimeW-1:0]   prime;
    logic [PrimeW-1:0]   residue;
    logic [WordIdxW-1:0] word;
  } sieve_item_t;

  typedef struct {
    logic [1:0]  action;
    logic [63:0] word;
  } sieve_result_t;

  // ports
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                start_i         = 1'b0;
  logic                busy_o;
  logic [1:0]          action_i        = '0;
  logic [PrimeW-1:0]   sieving_prime_i = '0;
  logic [PrimeW-1:0]   start_residue_i = '0;
  logic [WordIdxW-1:0] word_index_i    = '0;
  logic                valid_o;
  logic [1:0]          done_action_o;
  logic [63:0]         survivor_word_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i     = '0;
  logic [2:0]          cfg_data_i      = '0;

  // bench-side copy of the block state
  logic [63:0]   composite_map [SieveWords] = '{default: '0};
  logic [1:0]    res_three = '0;
  logic [2:0]    res_five  = '0;
  logic [2:0]    res_seven = '0;

  sieve_item_t   pending_items [$];
  sieve_result_t due_results [$];
  sieve_item_t   on_port;
  int unsigned   items_taken = 0;
  int unsigned   fault_count = 0;

  segmented_prime_sieve_marker_core #(
    .SIEVE_WORDS(SieveWords)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .sieving_prime_i(sieving_prime_i),
    .start_residue_i(start_residue_i),
    .word_index_i   (word_index_i),
    .valid_o        (valid_o),
    .done_action_o  (done_action_o),
    .survivor_word_o(survivor_word_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  // distance from the start number up to the next multiple of modulus
  function automatic int unsigned wheel_gap(input int unsigned res, input int unsigned modulus);
    int unsigned r;
    r = res % modulus;
    return (r == 0) ? 0 : modulus - r;
  endfunction

  // first odd multiple of p past the start, then every second multiple to the end
  function automatic void mark_multiples(input logic [PrimeW-1:0] p,
                                         input logic [PrimeW-1:0] r);
    logic [63:0] pos;
    logic [63:0] stride;
    if (p < 32'd3 || r >= p) return;
    pos = 64'(p - r);
    if (pos == 64'(p)) pos = '0;
    if (!pos[0]) pos = pos + 64'(p);
    stride = 64'(p) << 1;
    while (pos < TotalBits) begin
      composite_map[pos >> 6][pos[5:0]] = 1'b1;
      pos = pos + stride;
    end
  endfunction

  // odd, unmarked offsets whose numbers escape 3, 5 and 7
  function automatic logic [63:0] survivor_bits(input logic [WordIdxW-1:0] w);
    logic [63:0] res;
    logic [63:0] marks;
    int unsigned o3, o5, o7, i;
    res = '0;
    if (w >= SieveWords) return res;
    o3 = wheel_gap(res_three, 3);
    o5 = wheel_gap(res_five, 5);
    o7 = wheel_gap(res_seven, 7);
    marks = composite_map[w];
    // word base is even, so odd offsets sit at odd k
    for (int k = 1; k < 64; k += 2) begin
      i = (int'(w) << 6) + k;
      if (!marks[k] && i % 3 != o3 && i % 5 != o5 && i % 7 != o7) res[k] = 1'b1;
    end
    return res;
  endfunction

  function automatic sieve_result_t sieve_outcome(input sieve_item_t it);
    sieve_result_t out;
    out.action = it.action;
    out.word   = '0;
    case (it.action)
      ACT_CLEAR: foreach (composite_map[j]) composite_map[j] = '0;
      ACT_MARK:  mark_multiples(it.prime, it.residue);
      ACT_READ:  out.word = survivor_bits(it.word);
      default:   ;
    endcase
    return out;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb_top: %s mismatch at %0t ns: got %h want %h", what, $time, got, want);
    fault_count++;
  endtask

  // ---------------------------------------------------------------- driver

  // Offers the next pending item, holds it until taken. Idles ~22% of the time
  // except for a quiet stretch of items 400..699 where items go back to back.
  always @(posedge clk_i) begin : item_driver
    sieve_item_t nxt;
    logic        taken;
    logic        hold_back;
    taken     = (start_i === 1'b1) && (busy_o === 1'b0);
    hold_back = (items_taken < 400 || items_taken >= 700) && ($urandom_range(99) < 22);
    if (taken) begin
      due_results.insert(due_results.size(), sieve_outcome(on_port));
      items_taken++;
    end
    if (taken || start_i !== 1'b1) begin
      if (pending_items.size() != 0 && !hold_back) begin
        nxt             = pending_items.pop_front();
        on_port         = nxt;
        start_i         <= 1'b1;
        action_i        <= nxt.action;
        sieving_prime_i <= nxt.prime;
        start_residue_i <= nxt.residue;
        word_index_i    <= nxt.word;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : result_monitor
    sieve_result_t want;
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", {62'b0, done_action_o}, '0);
      end else begin
        want = due_results.pop_front();
        if (done_action_o !== want.action) begin
          report_mismatch("done_action", 64'(done_action_o), 64'(want.action));
        end
        if (survivor_word_o !== want.word) begin
          report_mismatch("survivor_word", survivor_word_o, want.word);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_item(input logic [1:0] act, input logic [PrimeW-1:0] p,
                            input logic [PrimeW-1:0] r, input logic [WordIdxW-1:0] w);
    sieve_item_t it;
    it.action  = act;
    it.prime   = p;
    it.residue = r;
    it.word    = w;
    pending_items.insert(pending_items.size(), it);
  endtask

  // residue register write; only called with the block idle
  task automatic write_residue(input logic [1:0] idx, input logic [2:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegModThree: res_three = data[1:0];
      RegModFive:  res_five  = data;
      RegModSeven: res_seven = data;
      default:     ;
    endcase
  endtask

  // sender pauses until every prediction is met and the block is free
  task automatic settle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || start_i !== 1'b0 || due_results.size() != 0 ||
           busy_o !== 1'b0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    sieve_item_t it;
    int unsigned sel;
    int unsigned pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // bitmap sweep after reset keeps busy_o high
    do @(posedge clk_i); while (busy_o !== 1'b0);

    // wheel filter at reset residues, then a fixed setting for the directed part
    queue_item(ACT_READ, '0, '0, '0);
    settle();
    write_residue(RegModThree, 3'd1);
    write_residue(RegModFive,  3'd2);
    write_residue(RegModSeven, 3'd3);

    queue_item(ACT_READ, '0, '0, 14'd0);
    queue_item(ACT_READ, '0, '0, 14'h3FFF);
    // marks that must leave the bitmap alone: small primes, residue not below prime
    queue_item(ACT_MARK, 32'd0, 32'd0, '0);
    queue_item(ACT_MARK, 32'd1, 32'd0, '0);
    queue_item(ACT_MARK, 32'd2, 32'd1, '0);
    queue_item(ACT_MARK, 32'd11, 32'd11, '0);
    queue_item(ACT_MARK, 32'hFFFF_FFFE, 32'hFFFF_FFFF, '0);
    // widest prime: first hit at offset 1 only, or past the end
    queue_item(ACT_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFE, '0);
    queue_item(ACT_MARK, 32'hFFFF_FFFF, 32'd0, '0);
    // zero residue bumped to p; even prime takes the same rule
    queue_item(ACT_MARK, 32'd101, 32'd0, '0);
    queue_item(ACT_MARK, 32'd1000, 32'd3, '0);
    queue_item(ACT_MARK, 32'd997, 32'd990, '0);
    queue_item(ACT_MARK, 32'd31, 32'd5, '0);
    queue_item(ACT_READ, '0, '0, 14'd0);
    queue_item(ACT_READ, '0, '0, 14'd1);
    queue_item(ACT_READ, '0, '0, 14'd15);
    queue_item(ACT_READ, '0, '0, 14'd8191);
    queue_item(ACT_READ, '0, '0, 14'h3FFF);
    queue_item(ActUnknown, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF);
    queue_item(ActUnknown, '0, '0, '0);
    queue_item(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF);
    queue_item(ACT_READ, '0, '0, 14'd0);
    queue_item(ACT_MARK, 32'h0001_0001, 32'h0000_FFFF, '0);
    queue_item(ACT_READ, '0, '0, 14'd1024);
    settle();

    for (int ph = 0; ph < Phases; ph++) begin
      // residue settings: reset values, raw values at or above the moduli, in-range tops, then random
      case (ph)
        0: begin
          write_residue(RegModThree, 3'd0);
          write_residue(RegModFive,  3'd0);
          write_residue(RegModSeven, 3'd0);
        end
        1: begin
          write_residue(RegModThree, 3'd7);
          write_residue(RegModFive,  3'd7);
          write_residue(RegModSeven, 3'd7);
        end
        2: begin
          write_residue(RegModThree, 3'd2);
          write_residue(RegModFive,  3'd4);
          write_residue(RegModSeven, 3'd6);
        end
        default: begin
          if (ph == 3) write_residue(RegSpare, 3'($urandom));
          write_residue(RegModThree, 3'($urandom));
          write_residue(RegModFive,  3'($urandom));
          write_residue(RegModSeven, 3'($urandom));
        end
      endcase

      // each phase is a sieve pass: clear, then marks interleaved with reads, unknown actions and rare clears
      queue_item(ACT_CLEAR, $urandom, $urandom, 14'($urandom));
      for (int n = 0; n < PhaseItems; n++) begin
        it.action  = ACT_READ;
        it.prime   = $urandom;
        it.residue = $urandom;
        it.word    = 14'($urandom);
        sel = $urandom_range(999);
        if (sel < 4) begin
          it.action = ACT_CLEAR;
        end else if (sel < 424) begin
          it.action = ACT_MARK;
          pick = $urandom_range(99);
          // mostly mid-sized odd primes; small ones are slow, so rare
          if (pick < 3)       it.prime = $urandom_range(499, 31);
          else if (pick < 70) it.prime = $urandom_range(65535, 500);
          else if (pick < 92 && pick >= 85) it.prime = $urandom_range(2, 0);
          if (pick < 70 && $urandom_range(99) < 85) it.prime[0] = 1'b1;
          if (pick >= 92) begin
            it.prime   = $urandom_range(65535, 3);
            it.residue = $urandom_range(32'hFFFF_FFFF, it.prime);
          end else if (pick < 85 && it.prime != 0) begin
            it.residue = $urandom_range(it.prime - 1, 0);
          end
        end else if (sel < 454) begin
          it.action = ActUnknown;
        end else begin
          pick = $urandom_range(99);
          // low words are where the marks of mid-sized primes land
          if (pick < 75)      it.word = 14'($urandom_range(63, 0));
          else if (pick < 85) it.word = 14'($urandom_range(2047, 0));
        end
        pending_items.insert(pending_items.size(), it);
      end
      settle();
    end

    if (fault_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : run_limit
    #(LimitNs);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
